// ----- rtl/core/grid_spiral_free_cell_search_core_assert.svh -----
// assertion macros for the spiral free cell search core
// no dependencies, included by the top level only
`ifndef GRID_SPIRAL_FREE_CELL_SEARCH_CORE_ASSERT_SVH
`define GRID_SPIRAL_FREE_CELL_SEARCH_CORE_ASSERT_SVH

// same cycle implication, checked outside reset
`define GSFCS_ASSERT_HOLD(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next cycle implication, checked outside reset
`define GSFCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/gsfcs_pkg.sv -----
// shared types and constants of the spiral free cell search core
// no dependencies
package gsfcs_pkg;

    // request command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAV_THR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RINGS    = 2'd3;
    localparam int unsigned CFG_DATA_W = 16;

    // register reset values
    localparam logic signed [15:0] RST_ORIGIN_X = 16'sd2000;
    localparam logic signed [15:0] RST_ORIGIN_Y = -16'sd500;
    localparam logic [7:0]         RST_TRAV_THR = 8'd252;
    localparam logic [3:0]         RST_RINGS    = 4'd8;

    // divide by 20: shift by 2, then multiply by reciprocal of 5
    localparam logic [15:0] RECIP5     = 16'd52429;
    localparam int unsigned RECIP5_SH  = 18;

    // centre cell index, grid coordinate, ring offset and offset in mm
    typedef logic signed [12:0] t_cidx;
    typedef logic signed [13:0] t_coord;
    typedef logic signed [6:0]  t_off;
    typedef logic signed [11:0] t_offmm;

    // one map cell
    typedef struct packed {
        logic [7:0]  trav;
        logic [15:0] elev;
    } t_cell;

    // ring side being walked
    typedef enum logic [1:0] {
        SIDE_EAST,
        SIDE_SOUTH,
        SIDE_WEST,
        SIDE_NORTH
    } t_side;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CTR,
        S_CREQ,
        S_CCHK,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// ----- rtl/core/gsfcs_req_if.sv -----
// request channel: map writes and foothold queries
// no dependencies
interface gsfcs_req_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [6:0]         cell_x;
    logic [6:0]         cell_y;
    logic [7:0]         trav_value;
    logic signed [15:0] elev_value;
    logic signed [15:0] query_x_mm;
    logic signed [15:0] query_y_mm;

    modport source (
        output valid, cmd, cell_x, cell_y, trav_value, elev_value, query_x_mm, query_y_mm,
        input  ready
    );
    modport sink (
        input  valid, cmd, cell_x, cell_y, trav_value, elev_value, query_x_mm, query_y_mm,
        output ready
    );
endinterface

// ----- rtl/core/gsfcs_rsp_if.sv -----
// response channel: chosen foothold per query
// no dependencies
interface gsfcs_rsp_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic signed [15:0] foot_x_mm;
    logic signed [15:0] foot_y_mm;
    logic signed [15:0] foot_z_mm;

    modport source (
        output valid, found, foot_x_mm, foot_y_mm, foot_z_mm,
        input  ready
    );
    modport sink (
        input  valid, found, foot_x_mm, foot_y_mm, foot_z_mm,
        output ready
    );
endinterface

// ----- rtl/core/grid_spiral_free_cell_search_core.sv -----
// Write request: one write per cycle while idle; none is taken during a query. Query: the DIV,
// CTR and CREQ states lead to the centre check, then one map read per cycle over rings 1..R
// (8*L cells for ring L, 4*R*(R+1) at most); the result waits for a free output register.
// The rate is set by the single read port of the map memory, one cell per cycle.
// Reset loads the register defaults and empties the output; the map is not cleared.
// Depends on gsfcs_pkg, gsfcs_req_if, gsfcs_rsp_if and the assertion macro header.
`include "grid_spiral_free_cell_search_core_assert.svh"

module grid_spiral_free_cell_search_core
    import gsfcs_pkg::*;
#(
    parameter int GRID_COLS = 128,
    parameter int GRID_ROWS = 128,
    parameter int MAX_RINGS = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gsfcs_req_if.sink             i_req,
    gsfcs_rsp_if.source           o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int XW = $clog2(GRID_COLS);
    localparam int YW = $clog2(GRID_ROWS);
    localparam int AW = $clog2(GRID_COLS * GRID_ROWS);
    localparam int LW = $clog2(MAX_RINGS + 1);
    localparam int DEPTH = GRID_COLS * GRID_ROWS;
    localparam t_off OFF_ONE = 7'sd1;

    // cell lies inside the map
    function automatic logic in_grid(t_coord x, t_coord y);
        return (x >= 0) && (x < GRID_COLS) && (y >= 0) && (y < GRID_ROWS);
    endfunction

    // row major cell address
    function automatic logic [AW-1:0] cell_addr(t_coord x, t_coord y);
        logic [AW-1:0] xa;
        logic [AW-1:0] ya;
        xa = AW'(x[XW-1:0]);
        ya = AW'(y[YW-1:0]);
        return ya * AW'(GRID_COLS) + xa;
    endfunction

    // saturating add of a cell offset to a position
    function automatic logic signed [15:0] add_sat(logic signed [15:0] q, t_offmm o);
        logic signed [16:0] s;
        s = 17'(q) + 17'(o);
        if (s[16] != s[15]) begin
            return s[16] ? 16'sh8000 : 16'sh7fff;
        end
        return s[15:0];
    endfunction

    // configuration registers
    logic signed [15:0] r_org_x;
    logic signed [15:0] r_org_y;
    logic [7:0]         r_thr;
    logic [3:0]         r_sr;

    // control state
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_pv, n_pv;
    logic   r_more, n_more;

    // query datapath
    logic signed [15:0] r_qx, n_qx;
    logic signed [15:0] r_qy, n_qy;
    logic [11:0]        r_magx, n_magx;
    logic [11:0]        r_magy, n_magy;
    logic               r_negx, n_negx;
    logic               r_negy, n_negy;
    t_cidx              r_cx, n_cx;
    t_cidx              r_cy, n_cy;
    logic               r_cin_c, n_cin_c;
    logic               r_cneg, n_cneg;
    logic [15:0]        r_ctr_z, n_ctr_z;
    logic [LW-1:0]      r_rings, n_rings;
    logic [LW-1:0]      r_ring, n_ring;
    t_side              r_side, n_side;
    t_off               r_idx, n_idx;
    logic               r_pin, n_pin;
    t_offmm             r_pox_mm, n_pox_mm;
    t_offmm             r_poy_mm, n_poy_mm;

    // result and output registers
    logic               r_res_found, n_res_found;
    logic signed [15:0] r_res_x, n_res_x;
    logic signed [15:0] r_res_y, n_res_y;
    logic signed [15:0] r_res_z, n_res_z;
    logic               r_o_found, n_o_found;
    logic signed [15:0] r_o_x, n_o_x;
    logic signed [15:0] r_o_y, n_o_y;
    logic signed [15:0] r_o_z, n_o_z;

    // map memory
    t_cell              r_grid [DEPTH];
    t_cell              r_rd;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [AW-1:0]      w_raddr;

    // handshake
    logic w_acc;
    logic w_load;

    // combinational helpers
    logic signed [16:0] w_dx;
    logic signed [16:0] w_dy;
    logic [15:0]        w_absx;
    logic [15:0]        w_absy;
    logic [29:0]        w_prodx;
    logic [29:0]        w_prody;
    t_coord             w_crx;
    t_coord             w_cry;
    logic               w_ctr_pass;
    logic               w_scan_pass;
    t_off               w_ls;
    t_off               w_ox;
    t_off               w_oy;
    logic               w_side_end;
    t_coord             w_srx;
    t_coord             w_sry;
    logic [3:0]         w_sr_lim;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.found     = r_o_found;
    assign o_rsp.foot_x_mm = r_o_x;
    assign o_rsp.foot_y_mm = r_o_y;
    assign o_rsp.foot_z_mm = r_o_z;

    // map write port
    assign w_we = w_acc && (i_req.cmd == CMD_WRITE)
                  && (32'(i_req.cell_x) < GRID_COLS) && (32'(i_req.cell_y) < GRID_ROWS);
    assign w_waddr = cell_addr(t_coord'(i_req.cell_x), t_coord'(i_req.cell_y));

    // centre offset magnitude divided by 20
    assign w_dx    = 17'(r_qx) - 17'(r_org_x);
    assign w_dy    = 17'(r_qy) - 17'(r_org_y);
    assign w_absx  = w_dx[16] ? 16'(-w_dx) : w_dx[15:0];
    assign w_absy  = w_dy[16] ? 16'(-w_dy) : w_dy[15:0];
    assign w_prodx = 30'(w_absx[15:2]) * 30'(RECIP5);
    assign w_prody = 30'(w_absy[15:2]) * 30'(RECIP5);

    // centre cell, negative x read at column zero
    assign w_crx = (r_cx < 0) ? t_coord'(0) : t_coord'(r_cx);
    assign w_cry = t_coord'(r_cy);
    assign w_ctr_pass  = r_cin_c && (r_rd.trav > r_thr);
    assign w_scan_pass = r_pv && r_pin && (r_rd.trav > r_thr);

    // ring walk offsets for the current step
    assign w_ls = t_off'(r_ring);
    always_comb begin
        w_ox = w_ls;
        w_oy = r_idx;
        w_side_end = 1'b0;
        case (r_side)
            SIDE_EAST: begin
                w_ox = w_ls;
                w_oy = r_idx;
                w_side_end = (r_idx == OFF_ONE - w_ls);
            end
            SIDE_SOUTH: begin
                w_ox = r_idx;
                w_oy = -w_ls;
                w_side_end = (r_idx == OFF_ONE - w_ls);
            end
            SIDE_WEST: begin
                w_ox = -w_ls;
                w_oy = r_idx;
                w_side_end = (r_idx == w_ls - OFF_ONE);
            end
            SIDE_NORTH: begin
                w_ox = r_idx;
                w_oy = w_ls;
                w_side_end = (r_idx == w_ls - OFF_ONE);
            end
            default: begin
                w_ox = w_ls;
                w_oy = r_idx;
                w_side_end = 1'b0;
            end
        endcase
    end

    // ring cell, negative x read at column zero
    always_comb begin
        w_srx = t_coord'(r_cx) + t_coord'(w_ox);
        if (w_srx < 0) begin
            w_srx = t_coord'(0);
        end
        w_sry = t_coord'(r_cy) + t_coord'(w_oy);
    end

    assign w_raddr = (r_state == S_CREQ) ? cell_addr(w_crx, w_cry) : cell_addr(w_srx, w_sry);
    assign w_sr_lim = (32'(r_sr) > MAX_RINGS) ? 4'(MAX_RINGS) : r_sr;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && (i_req.cmd == CMD_QUERY)) begin
                    n_state = S_DIV;
                end
            end
            S_DIV:  n_state = S_CTR;
            S_CTR:  n_state = S_CREQ;
            S_CREQ: n_state = S_CCHK;
            S_CCHK: begin
                if (w_ctr_pass || (w_sr_lim == 4'd0)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_pass || !r_more) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_qx        = r_qx;
        n_qy        = r_qy;
        n_magx      = r_magx;
        n_magy      = r_magy;
        n_negx      = r_negx;
        n_negy      = r_negy;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_cin_c     = r_cin_c;
        n_cneg      = r_cneg;
        n_ctr_z     = r_ctr_z;
        n_rings     = r_rings;
        n_ring      = r_ring;
        n_side      = r_side;
        n_idx       = r_idx;
        n_pv        = 1'b0;
        n_more      = r_more;
        n_pin       = r_pin;
        n_pox_mm    = r_pox_mm;
        n_poy_mm    = r_poy_mm;
        n_res_found = r_res_found;
        n_res_x     = r_res_x;
        n_res_y     = r_res_y;
        n_res_z     = r_res_z;
        n_o_found   = r_o_found;
        n_o_x       = r_o_x;
        n_o_y       = r_o_y;
        n_o_z       = r_o_z;
        n_out_valid = o_rsp.ready ? 1'b0 : r_out_valid;

        case (r_state)
            // latch the query position
            S_IDLE: begin
                if (w_acc) begin
                    n_qx = i_req.query_x_mm;
                    n_qy = i_req.query_y_mm;
                end
            end
            // quotient magnitudes and signs
            S_DIV: begin
                n_magx = w_prodx[RECIP5_SH +: 12];
                n_magy = w_prody[RECIP5_SH +: 12];
                n_negx = w_dx[16];
                n_negy = w_dy[16];
            end
            // signed centre index
            S_CTR: begin
                n_cx = r_negx ? -t_cidx'(r_magx) : t_cidx'(r_magx);
                n_cy = r_negy ? -t_cidx'(r_magy) : t_cidx'(r_magy);
            end
            // centre read issued
            S_CREQ: begin
                n_cin_c = in_grid(w_crx, w_cry);
                n_cneg  = (r_cx < 0);
            end
            // centre check, else start the ring walk
            S_CCHK: begin
                n_ctr_z = (r_cin_c && !r_cneg) ? r_rd.elev : 16'd0;
                n_res_x = r_qx;
                n_res_y = r_qy;
                if (w_ctr_pass) begin
                    n_res_found = !r_cneg;
                    n_res_z     = r_cneg ? 16'sd0 : r_rd.elev;
                end else begin
                    n_res_found = 1'b0;
                    n_res_z     = (r_cin_c && !r_cneg) ? r_rd.elev : 16'sd0;
                end
                n_rings = LW'(w_sr_lim);
                n_ring  = LW'(1);
                n_side  = SIDE_EAST;
                n_idx   = OFF_ONE;
                n_more  = 1'b1;
            end
            // one ring cell read per cycle, check the one read the cycle before
            S_SCAN: begin
                if (w_scan_pass) begin
                    n_res_found = 1'b1;
                    n_res_x     = add_sat(r_qx, r_pox_mm);
                    n_res_y     = add_sat(r_qy, r_poy_mm);
                    n_res_z     = r_rd.elev;
                end else if (!r_more) begin
                    n_res_found = 1'b0;
                    n_res_x     = r_qx;
                    n_res_y     = r_qy;
                    n_res_z     = r_ctr_z;
                end else begin
                    n_pv     = 1'b1;
                    n_pin    = in_grid(w_srx, w_sry);
                    n_pox_mm = (t_offmm'(w_ox) <<< 4) + (t_offmm'(w_ox) <<< 2);
                    n_poy_mm = (t_offmm'(w_oy) <<< 4) + (t_offmm'(w_oy) <<< 2);
                    if (!w_side_end) begin
                        if (r_side == SIDE_EAST || r_side == SIDE_SOUTH) begin
                            n_idx = r_idx - OFF_ONE;
                        end else begin
                            n_idx = r_idx + OFF_ONE;
                        end
                    end else begin
                        case (r_side)
                            SIDE_EAST: begin
                                n_side = SIDE_SOUTH;
                                n_idx  = w_ls;
                            end
                            SIDE_SOUTH: begin
                                n_side = SIDE_WEST;
                                n_idx  = -w_ls;
                            end
                            SIDE_WEST: begin
                                n_side = SIDE_NORTH;
                                n_idx  = -w_ls;
                            end
                            SIDE_NORTH: begin
                                if (r_ring == r_rings) begin
                                    n_more = 1'b0;
                                end else begin
                                    n_ring = r_ring + LW'(1);
                                    n_side = SIDE_EAST;
                                    n_idx  = w_ls + OFF_ONE;
                                end
                            end
                            default: n_more = 1'b0;
                        endcase
                    end
                end
            end
            // move the result into the output register
            S_DONE: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_o_found   = r_res_found;
                    n_o_x       = r_res_x;
                    n_o_y       = r_res_y;
                    n_o_z       = r_res_z;
                end
            end
            default: begin
                n_pv = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_more      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pv        <= n_pv;
            r_more      <= n_more;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= RST_ORIGIN_X;
            r_org_y <= RST_ORIGIN_Y;
            r_thr   <= RST_TRAV_THR;
            r_sr    <= RST_RINGS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                CFG_TRAV_THR: r_thr   <= i_cfg_data[7:0];
                CFG_RINGS:    r_sr    <= i_cfg_data[3:0];
                default:      r_sr    <= r_sr;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_qx        <= n_qx;
        r_qy        <= n_qy;
        r_magx      <= n_magx;
        r_magy      <= n_magy;
        r_negx      <= n_negx;
        r_negy      <= n_negy;
        r_cx        <= n_cx;
        r_cy        <= n_cy;
        r_cin_c     <= n_cin_c;
        r_cneg      <= n_cneg;
        r_ctr_z     <= n_ctr_z;
        r_rings     <= n_rings;
        r_ring      <= n_ring;
        r_side      <= n_side;
        r_idx       <= n_idx;
        r_pin       <= n_pin;
        r_pox_mm    <= n_pox_mm;
        r_poy_mm    <= n_poy_mm;
        r_res_found <= n_res_found;
        r_res_x     <= n_res_x;
        r_res_y     <= n_res_y;
        r_res_z     <= n_res_z;
        r_o_found   <= n_o_found;
        r_o_x       <= n_o_x;
        r_o_y       <= n_o_y;
        r_o_z       <= n_o_z;
    end

    // map memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_grid[w_waddr] <= '{trav: i_req.trav_value, elev: i_req.elev_value};
        end
        r_rd <= r_grid[w_raddr];
    end

    // checks
    `GSFCS_ASSERT_HOLD(a_rsp_from_done, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state == S_DONE), "response raised outside the done state")
    `GSFCS_ASSERT_HOLD(a_ring_in_range, i_clk, i_rst_n, (r_state == S_SCAN) && r_more,
        (r_ring != '0) && (r_ring <= r_rings), "ring counter outside the searched rings")
    `GSFCS_ASSERT_NEXT(a_read_in_scan, i_clk, i_rst_n, r_pv,
        (r_state == S_SCAN) || (r_state == S_DONE), "pending ring read outside the scan")

endmodule

// ----- tb/grid_spiral_free_cell_search_core_tb.sv -----
// testbench for the spiral free cell search core: map writes and foothold queries
// with a scoreboard that predicts every foothold from its own copy of map and registers
// depends on gsfcs_pkg, gsfcs_req_if, gsfcs_rsp_if and the core itself
module grid_spiral_free_cell_search_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gsfcs_pkg::*;

    localparam int COLS             = 128;
    localparam int ROWS             = 128;
    localparam int RING_CAP         = 15;
    localparam int MAP_CELLS        = COLS * ROWS;
    localparam int STEP_MM          = 20;
    localparam int SETTLE_CYCLES    = 16;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TIMEOUT_NS       = 10_000_000;
    localparam int REPORT_CAP       = 100;

    // one request as the sender builds it
    typedef struct {
        logic               cmd;
        logic [6:0]         cell_x;
        logic [6:0]         cell_y;
        logic [7:0]         trav_value;
        logic signed [15:0] elev_value;
        logic signed [15:0] query_x_mm;
        logic signed [15:0] query_y_mm;
    } map_req_t;

    // one chosen foothold
    typedef struct {
        logic               found;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } foothold_t;

    // receiver stall patterns
    typedef enum int {RX_OPEN, RX_SPARSE, RX_COMB, RX_COIN} stall_mode_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gsfcs_req_if req_ch ();
    gsfcs_rsp_if rsp_ch ();

    grid_spiral_free_cell_search_core #(
        .GRID_COLS (COLS),
        .GRID_ROWS (ROWS),
        .MAX_RINGS (RING_CAP)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // saturate a millimetre value to the signed 16 bit range
    function automatic logic signed [15:0] sat_mm(int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    // map copy, register copy and the queue of footholds still owed
    class foothold_board;
        logic [7:0]         trav_map [MAP_CELLS];
        logic signed [15:0] elev_map [MAP_CELLS];
        logic signed [15:0] org_x;
        logic signed [15:0] org_y;
        logic [7:0]         trav_min;
        logic [3:0]         ring_count;
        foothold_t          due_q [$];
        int unsigned        fails;

        function new();
            org_x      = RST_ORIGIN_X;
            org_y      = RST_ORIGIN_Y;
            trav_min   = RST_TRAV_THR;
            ring_count = RST_RINGS;
            fails      = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ORIGIN_X: org_x = data;
                CFG_ORIGIN_Y: org_y = data;
                CFG_TRAV_THR: trav_min = data[7:0];
                CFG_RINGS:    ring_count = data[3:0];
                default: ;
            endcase
        endfunction

        function bit on_map(int x, int y);
            return x >= 0 && x < COLS && y >= 0 && y < ROWS;
        endfunction

        // cells off the map never pass
        function bit cell_ok(int x, int y);
            if (!on_map(x, y)) return 1'b0;
            return trav_map[y * COLS + x] > trav_min;
        endfunction

        // cells off the map read as ground level
        function logic signed [15:0] height_at(int x, int y);
            if (!on_map(x, y)) return '0;
            return elev_map[y * COLS + x];
        endfunction

        // one probe at offset (ox, oy); a negative x index reads column 0
        function bit try_cell(int cx, int cy, int ox, int oy, int qx, int qy,
                              output foothold_t hit);
            int rx;
            rx = cx + ox;
            if (rx < 0) rx = 0;
            hit.found = 1'b1;
            hit.x     = sat_mm(qx + ox * STEP_MM);
            hit.y     = sat_mm(qy + oy * STEP_MM);
            hit.z     = height_at(rx, cy + oy);
            return cell_ok(rx, cy + oy);
        endfunction

        function foothold_t predict_foothold(logic signed [15:0] qx16, logic signed [15:0] qy16);
            int        qx, qy, cx, cy, span, lvl, i;
            foothold_t res;
            qx = qx16;
            qy = qy16;
            cx = (qx - int'(org_x)) / STEP_MM;
            cy = (qy - int'(org_y)) / STEP_MM;
            // centre probe reads the clamped column, but the verdict and
            // elevation come from the unclamped centre
            if (cell_ok(cx < 0 ? 0 : cx, cy)) begin
                res.found = cell_ok(cx, cy);
                res.x     = qx16;
                res.y     = qy16;
                res.z     = height_at(cx, cy);
                return res;
            end
            span = ring_count;
            if (span > RING_CAP) span = RING_CAP;
            // four sides per ring: east, south, west, north
            for (lvl = 1; lvl <= span; lvl++) begin
                for (i = lvl; i > -lvl; i--)
                    if (try_cell(cx, cy, lvl, i, qx, qy, res)) return res;
                for (i = lvl; i > -lvl; i--)
                    if (try_cell(cx, cy, i, -lvl, qx, qy, res)) return res;
                for (i = -lvl; i < lvl; i++)
                    if (try_cell(cx, cy, -lvl, i, qx, qy, res)) return res;
                for (i = -lvl; i < lvl; i++)
                    if (try_cell(cx, cy, i, lvl, qx, qy, res)) return res;
            end
            // nothing passed: stay on the query with the centre elevation
            res.found = 1'b0;
            res.x     = qx16;
            res.y     = qy16;
            res.z     = height_at(cx, cy);
            return res;
        endfunction

        function void note_request(map_req_t r);
            int idx;
            if (r.cmd == CMD_WRITE) begin
                idx = int'(r.cell_y) * COLS + int'(r.cell_x);
                trav_map[idx] = r.trav_value;
                elev_map[idx] = r.elev_value;
            end else begin
                due_q.push_back(predict_foothold(r.query_x_mm, r.query_y_mm));
            end
        endfunction

        function void flag(string field, int want_v, int got_v);
            if (fails < REPORT_CAP)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want_v, got_v);
            fails++;
        endfunction

        function void check_footstep(foothold_t got);
            foothold_t want;
            if (due_q.size() == 0) begin
                if (fails < REPORT_CAP)
                    $display("%0t: response with no query waiting, expected none, actual %0b %0d %0d %0d",
                             $time, got.found, got.x, got.y, got.z);
                fails++;
                return;
            end
            want = due_q.pop_front();
            if (got.found !== want.found) flag("found", want.found, got.found);
            if (got.x !== want.x) flag("foot_x_mm", want.x, got.x);
            if (got.y !== want.y) flag("foot_y_mm", want.y, got.y);
            if (got.z !== want.z) flag("foot_z_mm", want.z, got.z);
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    foothold_board board = new();

    int burst_left = 0;
    bit steady     = 1'b0;
    int long_hold  = 0;

    // clock, 2 ns period
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // request builders
    function automatic map_req_t cell_write(int x, int y, int trav, int elev);
        map_req_t r;
        r.cmd        = CMD_WRITE;
        r.cell_x     = 7'(x);
        r.cell_y     = 7'(y);
        r.trav_value = 8'(trav);
        r.elev_value = 16'(elev);
        r.query_x_mm = 16'($urandom);
        r.query_y_mm = 16'($urandom);
        return r;
    endfunction

    function automatic map_req_t foot_query(int qx, int qy);
        map_req_t r;
        r.cmd        = CMD_QUERY;
        r.cell_x     = 7'($urandom);
        r.cell_y     = 7'($urandom);
        r.trav_value = 8'($urandom);
        r.elev_value = 16'($urandom);
        r.query_x_mm = sat_mm(qx);
        r.query_y_mm = sat_mm(qy);
        return r;
    endfunction

    // a position inside cell c, on the negative side of the origin at times for c = 0
    function automatic int aim_mm(int origin, int c);
        int off;
        off = $urandom_range(0, 19);
        if (c < 0 || (c == 0 && $urandom_range(0, 1) == 1)) return origin + c * STEP_MM - off;
        return origin + c * STEP_MM + off;
    endfunction

    function automatic int to_grid(int v, int n);
        if (v < 0) return 0;
        if (v > n - 1) return n - 1;
        return v;
    endfunction

    // offer one request in bursts with random gaps; valid stays high on return,
    // so the caller offers again or settles in the same step
    task automatic offer(map_req_t r);
        int gap;
        if (burst_left == 0 && !steady) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= r.cmd;
        req_ch.cell_x     <= r.cell_x;
        req_ch.cell_y     <= r.cell_y;
        req_ch.trav_value <= r.trav_value;
        req_ch.elev_value <= r.elev_value;
        req_ch.query_x_mm <= r.query_x_mm;
        req_ch.query_y_mm <= r.query_y_mm;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        board.note_request(r);
        if (burst_left > 0) burst_left--;
    endtask

    // stop sending and wait for every owed foothold, then for a write to land
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.set_register(idx, data);
    endtask

    task automatic program_config(logic signed [15:0] ox, logic signed [15:0] oy,
                                  logic [7:0] thr, logic [3:0] rings);
        settle();
        put_register(CFG_ORIGIN_X, ox);
        put_register(CFG_ORIGIN_Y, oy);
        put_register(CFG_TRAV_THR, {8'd0, thr});
        put_register(CFG_RINGS, {12'd0, rings});
        i_cfg_we <= 1'b0;
    endtask

    // mix of stray writes, planted cells followed by a query, aimed and wild queries
    task automatic mixed_traffic(int count, int x_lo, int x_hi, int y_lo, int y_hi);
        int done, pick, tx, ty, px, py, reach, low_pass;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            tx   = x_lo + int'($urandom_range(0, x_hi - x_lo));
            ty   = y_lo + int'($urandom_range(0, y_hi - y_lo));
            if (pick < 15) begin
                offer(cell_write($urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1),
                                 $urandom_range(0, 255), $urandom));
                done++;
            end else if (pick < 40) begin
                // plant a passing cell within reach, then ask around it
                reach    = int'(board.ring_count);
                px       = to_grid(tx + int'($urandom_range(0, 2 * reach)) - reach, COLS);
                py       = to_grid(ty + int'($urandom_range(0, 2 * reach)) - reach, ROWS);
                low_pass = (board.trav_min == 8'd255) ? 0 : int'(board.trav_min) + 1;
                offer(cell_write(px, py, low_pass + int'($urandom_range(0, 255 - low_pass)),
                                 $urandom));
                offer(foot_query(aim_mm(board.org_x, tx), aim_mm(board.org_y, ty)));
                done += 2;
            end else if (pick < 92) begin
                offer(foot_query(aim_mm(board.org_x, tx), aim_mm(board.org_y, ty)));
                done++;
            end else begin
                offer(foot_query(int'($urandom_range(0, 65535)) - 32768,
                                 int'($urandom_range(0, 65535)) - 32768));
                done++;
            end
        end
    endtask

    // receiver: checks every accepted response and stalls on its own pattern
    initial begin : rsp_side
        stall_mode_t mode;
        int          mode_left;
        int          tick;
        foothold_t   seen;
        rsp_ch.ready = 1'b0;
        mode         = RX_OPEN;
        mode_left    = 0;
        tick         = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                seen.found = rsp_ch.found;
                seen.x     = rsp_ch.foot_x_mm;
                seen.y     = rsp_ch.foot_y_mm;
                seen.z     = rsp_ch.foot_z_mm;
                board.check_footstep(seen);
            end
            if (mode_left == 0) begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            tick++;
            if (long_hold > 0) begin
                long_hold--;
                rsp_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:   rsp_ch.ready <= 1'b1;
                    RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 99) >= 30);
                    RX_COMB:   rsp_ch.ready <= ((tick % 5) >= 2);
                    default:   rsp_ch.ready <= 1'(($urandom_range(0, 1)));
                endcase
            end
        end
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    // main sequence
    initial begin
        int x, y;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_WRITE;
        req_ch.cell_x     = '0;
        req_ch.cell_y     = '0;
        req_ch.trav_value = '0;
        req_ch.elev_value = '0;
        req_ch.query_x_mm = '0;
        req_ch.query_y_mm = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole map so no search ever reads an unwritten cell;
        // background stays below the high thresholds
        steady = 1'b1;
        for (y = 0; y < ROWS; y++)
            for (x = 0; x < COLS; x++)
                offer(cell_write(x, y, $urandom_range(0, 239), $urandom));
        steady = 1'b0;

        // directed requests under the reset registers
        offer(cell_write(0, 0, 255, -32768));
        offer(cell_write(COLS - 1, ROWS - 1, 255, 32767));
        offer(cell_write(64, 64, 0, 0));
        offer(foot_query(RST_ORIGIN_X + 5, RST_ORIGIN_Y + 5));
        offer(foot_query(RST_ORIGIN_X + 127 * STEP_MM + 19, RST_ORIGIN_Y + 127 * STEP_MM + 19));
        offer(foot_query(aim_mm(RST_ORIGIN_X, 64), aim_mm(RST_ORIGIN_Y, 64)));
        offer(foot_query(-32768, 32767));
        offer(foot_query(32767, -32768));
        // just below the origin: truncation toward zero lands on column 0
        offer(foot_query(RST_ORIGIN_X - 7, RST_ORIGIN_Y + 5));
        // centre left of the map whose clamped column passes: not found
        offer(cell_write(0, 10, 255, 777));
        offer(foot_query(RST_ORIGIN_X - 65, RST_ORIGIN_Y + 205));
        // ring cell reached through the clamped column
        offer(cell_write(0, 20, 254, -1234));
        offer(foot_query(RST_ORIGIN_X - 45, RST_ORIGIN_Y + 19 * STEP_MM + 5));
        // west side of ring 3
        offer(cell_write(40, 35, 253, 4321));
        offer(foot_query(aim_mm(RST_ORIGIN_X, 43), aim_mm(RST_ORIGIN_Y, 38)));
        // north side of ring 3
        offer(cell_write(50, 52, 255, -77));
        offer(foot_query(aim_mm(RST_ORIGIN_X, 48), aim_mm(RST_ORIGIN_Y, 49)));
        // east side of ring 2
        offer(cell_write(90, 90, 255, 9));
        offer(foot_query(aim_mm(RST_ORIGIN_X, 88), aim_mm(RST_ORIGIN_Y, 90)));
        // south side of ring 3
        offer(cell_write(100, 20, 255, 10));
        offer(foot_query(aim_mm(RST_ORIGIN_X, 100), aim_mm(RST_ORIGIN_Y, 23)));
        // one ring past the search limit
        offer(cell_write(20, 100, 255, 11));
        offer(foot_query(aim_mm(RST_ORIGIN_X, 29), aim_mm(RST_ORIGIN_Y, 100)));

        mixed_traffic(100, -3, COLS + 2, -3, ROWS + 2);

        // any nonzero trav passes, one ring; the receiver holds off so the core backs up
        program_config(16'sd0, 16'sd0, 8'd0, 4'd1);
        long_hold = LONG_HOLD_CYCLES;
        mixed_traffic(80, -3, COLS + 2, -3, ROWS + 2);

        // extreme origins, nothing passes, centre only
        program_config(16'sh8000, 16'sh7fff, 8'd255, 4'd0);
        mixed_traffic(40, -3, COLS + 2, -3, 3);

        // nothing passes over the widest search
        program_config(RST_ORIGIN_X, RST_ORIGIN_Y, 8'd255, 4'd15);
        mixed_traffic(10, 0, COLS - 1, 0, ROWS - 1);

        // low x and high y edges: saturated positions and clamped columns
        program_config(16'sh8000, 16'sd30367, 8'd250, 4'd9);
        offer(foot_query(-32768, 32767));
        mixed_traffic(70, -2, 10, 112, ROWS - 1);

        // centres at or left of column 0
        program_config(16'sh7fff, 16'sh8000, 8'd120, 4'd4);
        mixed_traffic(60, -10, 2, 0, ROWS - 1);

        // random settings, with a full pause between the halves
        program_config(16'($urandom_range(0, 6000) - 3000), 16'($urandom_range(0, 6000) - 3000),
                       8'($urandom_range(200, 254)), 4'($urandom_range(2, 6)));
        mixed_traffic(50, -3, COLS + 2, -3, ROWS + 2);
        settle();
        mixed_traffic(50, -3, COLS + 2, -3, ROWS + 2);

        // high x edge: positive saturation
        program_config(16'sd30367, RST_ORIGIN_Y, 8'd253, 4'd7);
        offer(foot_query(32767, aim_mm(RST_ORIGIN_Y, 60)));
        mixed_traffic(40, 112, COLS - 1, 0, ROWS - 1);

        settle();
        if (board.fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/gsfcs_pkg.sv
rtl/core/gsfcs_req_if.sv
rtl/core/gsfcs_rsp_if.sv
rtl/core/grid_spiral_free_cell_search_core.sv
tb/grid_spiral_free_cell_search_core_tb.sv
